@@ src/ncw_pkg.sv @@
package ncw_pkg;

  localparam int unsigned TIME_BITS_DEF = 64;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned WIN_W = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_CFG = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKET_LEN    = 8'd0,
    REG_INIT_CWND     = 8'd1,
    REG_MIN_CWND      = 8'd2,
    REG_MAX_CWND      = 8'd3,
    REG_INCREASE_UNIT = 8'd4
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] RST_PACKET_LEN    = 16'd1252;
  localparam logic [CFG_W-1:0] RST_INIT_CWND     = 16'd10;
  localparam logic [CFG_W-1:0] RST_MIN_CWND      = 16'd2;
  localparam logic [CFG_W-1:0] RST_MAX_CWND      = 16'd2000;
  localparam logic [CFG_W-1:0] RST_INCREASE_UNIT = 16'd1252;

  localparam logic [WIN_W-1:0] THRESH_UNSET = '1;

  // Clamp to the upper bound first, then to the lower bound, so the lower
  // bound wins when the two cross.
  function automatic logic [WIN_W-1:0] bound_bytes(
    input logic [WIN_W-1:0] w,
    input logic [WIN_W-1:0] hi,
    input logic [WIN_W-1:0] lo
  );
    logic [WIN_W-1:0] t;
    t = (w > hi) ? hi : w;
    return (t < lo) ? lo : t;
  endfunction

  localparam logic [WIN_W-1:0] RST_MAX_BYTES =
    WIN_W'(RST_MAX_CWND) * WIN_W'(RST_PACKET_LEN);
  localparam logic [WIN_W-1:0] RST_MIN_BYTES =
    WIN_W'(RST_MIN_CWND) * WIN_W'(RST_PACKET_LEN);
  localparam logic [WIN_W-1:0] RST_INIT_BYTES =
    WIN_W'(RST_INIT_CWND) * WIN_W'(RST_PACKET_LEN);
  localparam logic [WIN_W-1:0] RST_WINDOW =
    bound_bytes(RST_INIT_BYTES, RST_MAX_BYTES, RST_MIN_BYTES);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CFG_WRITE,
    OP_CFG_MAX,
    OP_CFG_MIN,
    OP_CFG_INIT,
    OP_CFG_LOAD,
    OP_LOAD,
    OP_EVAL,
    OP_DIV,
    OP_GROW_SIZE,
    OP_GROW_QUOT,
    OP_BOUND,
    OP_HALVE,
    OP_PERSIST,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_loss;
    logic persist;
    logic in_recovery;
    logic loss_new;
    logic slow;
    logic div_done;
  } dp_status_t;

endpackage

@@ src/ncw_if.sv @@
interface ncw_in_if #(
  parameter int unsigned TIME_BITS = ncw_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [TIME_BITS-1:0] sent_time;
  logic [15:0]          packet_bytes;
  logic [TIME_BITS-1:0] now_time;
  logic                 persistent_congestion;
  logic [31:0]          inflight_bytes;

  modport source (
    output valid, func, sent_time, packet_bytes, now_time, persistent_congestion,
    output inflight_bytes,
    input  ready
  );
  modport sink (
    input  valid, func, sent_time, packet_bytes, now_time, persistent_congestion,
    input  inflight_bytes,
    output ready
  );
endinterface

interface ncw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_bytes;
  logic [31:0] threshold_bytes;
  logic        slow_start;
  logic [31:0] writable_bytes;

  modport source (
    output valid, window_bytes, threshold_bytes, slow_start, writable_bytes,
    input  ready
  );
  modport sink (
    input  valid, window_bytes, threshold_bytes, slow_start, writable_bytes,
    output ready
  );
endinterface

interface ncw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ncw_pkg::CFG_IDX_W-1:0]  index;
  logic [ncw_pkg::CFG_W-1:0]      data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ src/ncw_div.sv @@
module ncw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ncw_pkg::WIN_W-1:0] dividend_i,
  input  logic [ncw_pkg::WIN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ncw_pkg::WIN_W-1:0] quotient_o
);

  localparam int unsigned W = ncw_pkg::WIN_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dq_q, dq_d;
  logic [W-1:0]     dvsr_q, dvsr_d;
  logic [W:0]       rem_shift;
  logic [W+1:0]     diff;

  // Restoring division, one quotient bit per cycle. A zero divisor yields
  // an all-ones quotient.
  assign rem_shift = {rem_q, dq_q[W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W - 1);
      rem_d  = '0;
      dq_d   = dividend_i;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      if (!diff[W+1]) begin
        rem_d = diff[W-1:0];
        dq_d  = {dq_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[W-1:0];
        dq_d  = {dq_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

@@ src/ncw_dp.sv @@
module ncw_dp #(
  parameter int unsigned TIME_BITS = ncw_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ncw_pkg::dp_cmd_t              cmd_i,
  output ncw_pkg::dp_status_t           status_o,
  input  logic [ncw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ncw_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          func_i,
  input  logic [TIME_BITS-1:0]          sent_time_i,
  input  logic [15:0]                   packet_bytes_i,
  input  logic [TIME_BITS-1:0]          now_time_i,
  input  logic                          persistent_congestion_i,
  input  logic [31:0]                   inflight_bytes_i,
  output logic [31:0]                   window_bytes_o,
  output logic [31:0]                   threshold_bytes_o,
  output logic                          slow_start_o,
  output logic [31:0]                   writable_bytes_o
);

  localparam int unsigned W = ncw_pkg::WIN_W;
  localparam int unsigned CW = ncw_pkg::CFG_W;

  logic [CW-1:0] pkt_len_q, init_q, min_q, max_q, inc_q;
  logic [W-1:0]  maxb_q, minb_q, prod_q;
  logic [W-1:0]  window_q, window_d;
  logic [W-1:0]  thresh_q, thresh_d;
  logic          rv_q, rv_d;
  logic [TIME_BITS-1:0] rec_end_q, rec_end_d;

  logic                 func_q, persist_q;
  logic [TIME_BITS-1:0] sent_q, now_q;
  logic [15:0]          size_q;
  logic [31:0]          inflight_q;

  logic in_rec_q, loss_new_q, slow_q;

  logic [CW-1:0] mul_a, mul_b;
  logic [W-1:0]  mul_p;
  logic [W-1:0]  grow_add;
  logic [W:0]    grow_sum;
  logic [W-1:0]  halved;
  logic          div_start, div_done;
  logic [W-1:0]  quot;

  logic [31:0] res_win_q, res_thr_q, res_wr_q;
  logic        res_ss_q;

  always_comb begin
    unique case (cmd_i.op)
      ncw_pkg::OP_CFG_MAX:  begin mul_a = max_q;  mul_b = pkt_len_q; end
      ncw_pkg::OP_CFG_MIN:  begin mul_a = min_q;  mul_b = pkt_len_q; end
      ncw_pkg::OP_CFG_INIT: begin mul_a = init_q; mul_b = pkt_len_q; end
      default:              begin mul_a = inc_q;  mul_b = size_q;    end
    endcase
  end

  assign mul_p     = W'(mul_a) * W'(mul_b);
  assign grow_add  = (cmd_i.op == ncw_pkg::OP_GROW_QUOT) ? quot : W'(size_q);
  assign grow_sum  = {1'b0, window_q} + {1'b0, grow_add};
  assign halved    = ncw_pkg::bound_bytes({1'b0, window_q[W-1:1]}, maxb_q, minb_q);
  assign div_start = (cmd_i.op == ncw_pkg::OP_DIV);

  ncw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (window_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    window_d  = window_q;
    thresh_d  = thresh_q;
    rv_d      = rv_q;
    rec_end_d = rec_end_q;
    case (cmd_i.op) inside
      ncw_pkg::OP_CFG_LOAD: window_d = ncw_pkg::bound_bytes(prod_q, maxb_q, minb_q);
      ncw_pkg::OP_GROW_SIZE, ncw_pkg::OP_GROW_QUOT: begin
        window_d = (grow_sum > {1'b0, maxb_q}) ? maxb_q : grow_sum[W-1:0];
      end
      ncw_pkg::OP_BOUND: window_d = ncw_pkg::bound_bytes(window_q, maxb_q, minb_q);
      ncw_pkg::OP_HALVE: begin
        window_d  = halved;
        thresh_d  = halved;
        rv_d      = 1'b1;
        rec_end_d = now_q;
      end
      ncw_pkg::OP_PERSIST: window_d = minb_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_len_q  <= ncw_pkg::RST_PACKET_LEN;
      init_q     <= ncw_pkg::RST_INIT_CWND;
      min_q      <= ncw_pkg::RST_MIN_CWND;
      max_q      <= ncw_pkg::RST_MAX_CWND;
      inc_q      <= ncw_pkg::RST_INCREASE_UNIT;
      maxb_q     <= ncw_pkg::RST_MAX_BYTES;
      minb_q     <= ncw_pkg::RST_MIN_BYTES;
      window_q   <= ncw_pkg::RST_WINDOW;
      thresh_q   <= ncw_pkg::THRESH_UNSET;
      rv_q       <= 1'b0;
      rec_end_q  <= '0;
      in_rec_q   <= 1'b0;
      loss_new_q <= 1'b0;
      slow_q     <= 1'b0;
    end else begin
      window_q  <= window_d;
      thresh_q  <= thresh_d;
      rv_q      <= rv_d;
      rec_end_q <= rec_end_d;
      if (cmd_i.op == ncw_pkg::OP_CFG_WRITE) begin
        unique case (cfg_index_i)
          ncw_pkg::REG_PACKET_LEN:    pkt_len_q <= cfg_data_i;
          ncw_pkg::REG_INIT_CWND:     init_q    <= cfg_data_i;
          ncw_pkg::REG_MIN_CWND:      min_q     <= cfg_data_i;
          ncw_pkg::REG_MAX_CWND:      max_q     <= cfg_data_i;
          ncw_pkg::REG_INCREASE_UNIT: inc_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == ncw_pkg::OP_CFG_MAX) begin
        maxb_q <= mul_p;
      end
      if (cmd_i.op == ncw_pkg::OP_CFG_MIN) begin
        minb_q <= mul_p;
      end
      if (cmd_i.op == ncw_pkg::OP_EVAL) begin
        in_rec_q   <= rv_q && (sent_q < rec_end_q);
        loss_new_q <= !rv_q || (rec_end_q < sent_q);
        slow_q     <= window_q < thresh_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ncw_pkg::OP_CFG_INIT || cmd_i.op == ncw_pkg::OP_EVAL) begin
      prod_q <= mul_p;
    end
    if (cmd_i.op == ncw_pkg::OP_LOAD) begin
      func_q     <= func_i;
      sent_q     <= sent_time_i;
      size_q     <= packet_bytes_i;
      now_q      <= now_time_i;
      persist_q  <= persistent_congestion_i;
      inflight_q <= inflight_bytes_i;
    end
    if (cmd_i.op == ncw_pkg::OP_RESULT) begin
      res_win_q <= window_q;
      res_thr_q <= thresh_q;
      res_ss_q  <= window_q < thresh_q;
      res_wr_q  <= (inflight_q > window_q) ? '0 : window_q - inflight_q;
    end
  end

  assign status_o.is_loss     = func_q;
  assign status_o.persist     = persist_q;
  assign status_o.in_recovery = in_rec_q;
  assign status_o.loss_new    = loss_new_q;
  assign status_o.slow        = slow_q;
  assign status_o.div_done    = div_done;

  assign window_bytes_o    = res_win_q;
  assign threshold_bytes_o = res_thr_q;
  assign slow_start_o      = res_ss_q;
  assign writable_bytes_o  = res_wr_q;

`ifndef SYNTHESIS
  // A new recovery copies the reduced window into the threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ncw_pkg::OP_HALVE) |=> (thresh_q == window_q))
    else $error("threshold does not match window after loss reduction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ncw_pkg::OP_BOUND) |=>
      (window_q >= minb_q) && (window_q <= maxb_q || window_q == minb_q))
    else $error("window outside its bounds after bounding");
`endif

endmodule

@@ src/ncw_ctrl.sv @@
module ncw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ncw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  output logic                          cfg_ready_o,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ncw_pkg::dp_cmd_t              cmd_o,
  input  ncw_pkg::dp_status_t           status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CFG_MAX,
    ST_CFG_MIN,
    ST_CFG_INIT,
    ST_CFG_LOAD,
    ST_EVAL,
    ST_DECIDE,
    ST_GROW_SIZE,
    ST_DIV,
    ST_DIV_WAIT,
    ST_GROW_QUOT,
    ST_BOUND,
    ST_HALVE,
    ST_PERSIST,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   cfg_hit;
  logic   out_free;

  assign cfg_hit  = cfg_index_i < ncw_pkg::CFG_IDX_W'(ncw_pkg::NUM_CFG);
  assign out_free = !out_valid_q || out_ready_i;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ncw_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.op = ncw_pkg::OP_CFG_WRITE;
          if (cfg_hit) begin
            state_d = ST_CFG_MAX;
          end
        end else if (in_valid_i) begin
          cmd_o.op = ncw_pkg::OP_LOAD;
          state_d  = ST_EVAL;
        end
      end
      ST_CFG_MAX: begin
        cmd_o.op = ncw_pkg::OP_CFG_MAX;
        state_d  = ST_CFG_MIN;
      end
      ST_CFG_MIN: begin
        cmd_o.op = ncw_pkg::OP_CFG_MIN;
        state_d  = ST_CFG_INIT;
      end
      ST_CFG_INIT: begin
        cmd_o.op = ncw_pkg::OP_CFG_INIT;
        state_d  = ST_CFG_LOAD;
      end
      ST_CFG_LOAD: begin
        cmd_o.op = ncw_pkg::OP_CFG_LOAD;
        state_d  = ST_IDLE;
      end
      ST_EVAL: begin
        cmd_o.op = ncw_pkg::OP_EVAL;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status_i.is_loss) begin
          if (status_i.in_recovery) begin
            state_d = ST_BOUND;
          end else if (status_i.slow) begin
            state_d = ST_GROW_SIZE;
          end else begin
            state_d = ST_DIV;
          end
        end else if (status_i.loss_new) begin
          state_d = ST_HALVE;
        end else if (status_i.persist) begin
          state_d = ST_PERSIST;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_GROW_SIZE: begin
        cmd_o.op = ncw_pkg::OP_GROW_SIZE;
        state_d  = ST_BOUND;
      end
      ST_DIV: begin
        cmd_o.op = ncw_pkg::OP_DIV;
        state_d  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_GROW_QUOT;
        end
      end
      ST_GROW_QUOT: begin
        cmd_o.op = ncw_pkg::OP_GROW_QUOT;
        state_d  = ST_BOUND;
      end
      ST_BOUND: begin
        cmd_o.op = ncw_pkg::OP_BOUND;
        state_d  = ST_RESULT;
      end
      ST_HALVE: begin
        cmd_o.op = ncw_pkg::OP_HALVE;
        state_d  = status_i.persist ? ST_PERSIST : ST_RESULT;
      end
      ST_PERSIST: begin
        cmd_o.op = ncw_pkg::OP_PERSIST;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.op = ncw_pkg::OP_RESULT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || (cmd_o.op == ncw_pkg::OP_RESULT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A new result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == ncw_pkg::OP_RESULT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_hit) |=> (state_q == ST_CFG_MAX))
    else $error("register write did not start a window reload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EVAL) && !in_ready_o)
    else $error("accepted request did not start evaluation");
`endif

endmodule

@@ src/newreno_congestion_window_core.sv @@
// A congestion-avoidance ack waits on the bit-serial divider before its result is
// valid; slow-start, recovery and loss requests take paths that do not use it.
// One request is in work at a time; the next is accepted back in the idle state,
// which the controller enters as the result enters the output register. A pending
// register write goes first, and a result still held there stalls the next result.
// A valid-index register write holds off both channels while the window reloads.
// Reset loads the default registers, the initial window and an unset threshold.
module newreno_congestion_window_core #(
  parameter int unsigned TIME_BITS = ncw_pkg::TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ncw_cfg_if.sink   cfg_i,
  ncw_in_if.sink    in_i,
  ncw_out_if.source out_o
);

  ncw_pkg::dp_cmd_t    cmd;
  ncw_pkg::dp_status_t status;

  ncw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_ready_o (cfg_i.ready),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ncw_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .status_o                (status),
    .cfg_index_i             (cfg_i.index),
    .cfg_data_i              (cfg_i.data),
    .func_i                  (in_i.func),
    .sent_time_i             (in_i.sent_time),
    .packet_bytes_i          (in_i.packet_bytes),
    .now_time_i              (in_i.now_time),
    .persistent_congestion_i (in_i.persistent_congestion),
    .inflight_bytes_i        (in_i.inflight_bytes),
    .window_bytes_o          (out_o.window_bytes),
    .threshold_bytes_o       (out_o.threshold_bytes),
    .slow_start_o            (out_o.slow_start),
    .writable_bytes_o        (out_o.writable_bytes)
  );

endmodule
